// ===== rtl/gfa_pkg.sv =====
// Shared types, constants and field functions for the GF(2^67) arithmetic unit.
// Field polynomial x^67 + x^5 + x^2 + x + 1. No dependencies.
package gfa_pkg;

    localparam int unsigned M = 67;
    localparam int unsigned NUM_STG = 14;

    typedef logic [M-1:0] elem_t;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_MUL = 2'd1,
        FUNC_SQR = 2'd2,
        FUNC_INV = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MSRC_NONE = 2'd0,
        MSRC_A    = 2'd1,
        MSRC_T3   = 2'd2,
        MSRC_SAVE = 2'd3
    } msrc_t;

    typedef struct packed {
        logic  inv;
        elem_t x;
        elem_t a;
        elem_t t3;
        elem_t sv;
    } pipe_t;

    localparam int unsigned STG_K [NUM_STG] = '{1, 3, 6, 0, 3, 8, 7, 3, 8, 8, 8, 8, 1, 1};
    localparam msrc_t STG_MSRC [NUM_STG] = '{MSRC_A, MSRC_T3, MSRC_NONE, MSRC_SAVE,
        MSRC_T3, MSRC_NONE, MSRC_SAVE, MSRC_T3, MSRC_NONE, MSRC_NONE, MSRC_NONE,
        MSRC_NONE, MSRC_SAVE, MSRC_NONE};
    localparam logic STG_SET_T3 [NUM_STG] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam logic STG_SAVE [NUM_STG] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    function automatic elem_t reduce(input logic [2*M-2:0] p);
        logic [M+3:0] h;
        logic [M+3:0] f;
        logic [3:0]   g;
        logic [M-1:0] r;
        h = {5'd0, p[2*M-2:M]};
        f = {4'd0, p[M-1:0]} ^ h ^ (h << 1) ^ (h << 2) ^ (h << 5);
        g = f[M+3:M];
        r = f[M-1:0] ^ {63'd0, g} ^ {62'd0, g, 1'b0} ^ {61'd0, g, 2'b0} ^ {58'd0, g, 5'b0};
        return r;
    endfunction

    function automatic elem_t gf_mul(input elem_t a, input elem_t b);
        logic [2*M-2:0] p;
        p = '0;
        for (int i = 0; i < M; i++) begin
            if (b[i]) begin
                p = p ^ ({{(M-1){1'b0}}, a} << i);
            end
        end
        return reduce(p);
    endfunction

    function automatic elem_t gf_sqr(input elem_t a);
        logic [2*M-2:0] p;
        p = '0;
        for (int i = 0; i < M; i++) begin
            p[2*i] = a[i];
        end
        return reduce(p);
    endfunction

endpackage

// ===== rtl/gf2_67_field_arithmetic_unit.sv =====
// Top level of the GF(2^67) arithmetic unit: entry stage and inversion chain.
// Depends on gfa_pkg, gfa_front and gfa_stage.
//
//  Channel   Direction  Content
//  s_axis    in         request: func, a_lo, a_hi, b_lo, b_hi
//  m_axis    out        result: res_lo, res_hi
//
// Every request passes fifteen register stages, one entry stage plus fourteen
// inversion stages, before its result can be taken.
// One request can enter each cycle unless an output stall has filled the entry stage.
// Reset clears only the stage valid bits. A stall at the output holds every
// full stage in place; empty stages keep filling.
module gf2_67_field_arithmetic_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,  // func, a_lo, a_hi, b_lo, b_hi
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [71:0]   m_axis_tdata   // res_lo, res_hi, zero padding
);

    gfa_pkg::pipe_t stg_data [gfa_pkg::NUM_STG+1];
    logic           stg_vld  [gfa_pkg::NUM_STG+1];
    logic           stg_rdy  [gfa_pkg::NUM_STG+1];

    gfa_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .func      (s_axis_tdata[1:0]),
        .a         (s_axis_tdata[68:2]),
        .b         (s_axis_tdata[135:69]),
        .out_valid (stg_vld[0]),
        .out_ready (stg_rdy[0]),
        .out_data  (stg_data[0])
    );

    for (genvar g = 0; g < gfa_pkg::NUM_STG; g++) begin : g_stage
        gfa_stage
        #(
            .K      (gfa_pkg::STG_K[g]),
            .MSRC   (gfa_pkg::STG_MSRC[g]),
            .SET_T3 (gfa_pkg::STG_SET_T3[g]),
            .SAVE   (gfa_pkg::STG_SAVE[g])
        )
        u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_vld[g]),
            .in_ready  (stg_rdy[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_vld[g+1]),
            .out_ready (stg_rdy[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    assign stg_rdy[gfa_pkg::NUM_STG] = m_axis_tready;
    assign m_axis_tvalid = stg_vld[gfa_pkg::NUM_STG];
    assign m_axis_tdata  = {5'd0, stg_data[gfa_pkg::NUM_STG].x};

endmodule

// ===== rtl/gfa_front.sv =====
// Entry stage: add, multiply, square, or first inversion step a^2 * a.
// Depends on gfa_pkg.
module gfa_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  gfa_pkg::elem_t    a,
    input  gfa_pkg::elem_t    b,
    output logic              out_valid,
    input  logic              out_ready,
    output gfa_pkg::pipe_t    out_data
);

    logic           vld_reg;
    logic           vld_next;
    gfa_pkg::pipe_t data_reg;
    gfa_pkg::pipe_t data_next;
    gfa_pkg::elem_t m1;
    gfa_pkg::elem_t m2;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        m1 = (func == gfa_pkg::FUNC_INV) ? gfa_pkg::gf_sqr(a) : a;
        m2 = (func == gfa_pkg::FUNC_MUL) ? b : a;
        data_next.inv = (func == gfa_pkg::FUNC_INV);
        data_next.a   = a;
        data_next.t3  = a;
        data_next.sv  = a;
        if (func == gfa_pkg::FUNC_ADD)
        begin
            data_next.x = a ^ b;
        end
        else
        begin
            data_next.x = gfa_pkg::gf_mul(m1, m2);
        end
        vld_next = in_ready ? in_valid : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/gfa_stage.sv =====
// One inversion chain stage: K squarings, then an optional multiply; other requests pass unchanged.
// Depends on gfa_pkg.
module gfa_stage
#(
    parameter int unsigned    K      = 1,
    parameter gfa_pkg::msrc_t MSRC   = gfa_pkg::MSRC_NONE,
    parameter logic           SET_T3 = 1'b0,
    parameter logic           SAVE   = 1'b0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gfa_pkg::pipe_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output gfa_pkg::pipe_t    out_data
);

    logic           vld_reg;
    logic           vld_next;
    gfa_pkg::pipe_t data_reg;
    gfa_pkg::pipe_t data_next;
    gfa_pkg::elem_t y;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        y = in_data.x;
        for (int i = 0; i < K; i++) begin
            y = gfa_pkg::gf_sqr(y);
        end
        case (MSRC)
            gfa_pkg::MSRC_A:    y = gfa_pkg::gf_mul(y, in_data.a);
            gfa_pkg::MSRC_T3:   y = gfa_pkg::gf_mul(y, in_data.t3);
            gfa_pkg::MSRC_SAVE: y = gfa_pkg::gf_mul(y, in_data.sv);
            default:            y = y;
        endcase
        data_next     = in_data;
        data_next.x   = in_data.inv ? y : in_data.x;
        data_next.t3  = SET_T3 ? y : in_data.t3;
        data_next.sv  = SAVE ? in_data.x : in_data.sv;
        vld_next      = in_ready ? in_valid : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/gfa_checker.sv =====
// Port-level checks for the GF(2^67) arithmetic unit, bound to the top level.
// Depends on gf2_67_field_arithmetic_unit.
module gfa_checker
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tready,
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [71:0]   m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[71:67] == 5'd0)
        else $error("padding bits not zero");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input blocked while output is empty");

endmodule

bind gf2_67_field_arithmetic_unit gfa_checker u_gfa_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
